>>> hw/rtl/d2q_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the D2Q9 BGK collision pipeline.
// No dependencies; imported by d2q_div and d2q9_bgk_collision.
package d2q_pkg;

	localparam int NUM_W      = 35;  // magnitude of a momentum sum
	localparam int DIV_BITS   = 33;  // quotient bits resolved by the divider
	localparam int DIV_STEP   = 3;   // quotient bits per divider stage
	localparam int DIV_STAGES = DIV_BITS / DIV_STEP;

	localparam logic signed [27:0] W_REST = 28'sd119304647;
	localparam logic signed [27:0] W_AXIS = 28'sd29826162;
	localparam logic signed [27:0] W_DIAG = 28'sd7456540;
	localparam logic signed [41:0] ONE_Q  = 42'sd268435456;
	localparam logic [30:0]        OMEGA_RESET = 31'h4000_0000;

	typedef struct packed {
		logic [31:0]         rem;
		logic [DIV_BITS-1:0] bits;
		logic [DIV_BITS-1:0] quo;
		logic [31:0]         den;
		logic                ovf;
	} div_st_t;

	typedef struct packed {
		logic                ovf;
		logic [DIV_BITS-1:0] quo;
	} div_res_t;

	typedef struct packed {
		logic [8:0][31:0] f;
		logic [31:0]      rho;
		logic             negx;
		logic             negy;
		logic             zero;
	} side_t;

	typedef struct packed {
		logic [8:0][31:0] f;
		logic [31:0]      rho;
		logic [31:0]      ux;
		logic [31:0]      uy;
	} node_t;

	// Restoring division, DIV_STEP quotient bits.
	function automatic div_st_t div_step(input div_st_t x);
		div_st_t     y;
		logic [32:0] r2;
		y = x;
		for (int j = 0; j < DIV_STEP; j++) begin
			r2 = {y.rem, y.bits[DIV_BITS-1]};
			y.bits = {y.bits[DIV_BITS-2:0], 1'b0};
			if (r2 >= {1'b0, y.den}) begin
				y.rem = 32'(r2 - {1'b0, y.den});
				y.quo = {y.quo[DIV_BITS-2:0], 1'b1};
			end else begin
				y.rem = r2[31:0];
				y.quo = {y.quo[DIV_BITS-2:0], 1'b0};
			end
		end
		return y;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [49:0] x);
		logic [31:0] r;
		if (x > 50'sd2147483647) begin
			r = 32'h7fff_ffff;
		end else if (x < -50'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/d2q9_bgk_collision.sv
`timescale 1ns / 1ps
// Top level of the D2Q9 BGK collision pipeline: moments, velocity divide, equilibrium, relax.
// Depends on d2q_pkg and d2q_div.
//
//  channel  | direction | contents
//  s_axis   | in        | nine populations, 32 bits each
//  m_axis   | out       | nine post-collision populations, density, velocity x, velocity y
//  cfg      | in        | relaxation rate, unsigned Q1.30
//
// One node enters per cycle unless m_axis stalls. Stages: the 11-stage velocity divider
// (3 quotient bits per stage), 3 moment stages and 7 velocity, equilibrium and relax stages.
// The whole pipeline advances together; a stall on m_axis freezes every stage and drops
// s_axis_tready in the same cycle. Reset clears the valid bits and sets omega to 1.0.
module d2q9_bgk_collision import d2q_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// pop_rest, pop_east, pop_north, pop_west, pop_south, pop_northeast,
	// pop_northwest, pop_southwest, pop_southeast (32 bits each, lowest first)
	input  logic [287:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_rest .. out_southeast, density, velocity_x, velocity_y (32 bits each, lowest first)
	output logic [383:0] m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [30:0]  cfg_data
);

	logic en;
	logic [30:0] omega_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic [DIV_STAGES-1:0] vd_s;

	logic [8:0][31:0] f_s1;
	logic [8:0][31:0] f_s2;
	logic signed [35:0] sum_s2;
	logic signed [34:0] mx_s2, my_s2;
	side_t side_s3;
	logic [NUM_W-1:0] mxm_s3, mym_s3;
	logic [31:0] den_s3;
	side_t side_s [DIV_STAGES];
	div_res_t resx, resy;

	node_t node_s4, node_s5, node_s6, node_s7, node_s8, node_s9;
	logic signed [35:0] uxx_s5, uyy_s5, uxy_s5;
	logic signed [33:0] ux3_s5, uy3_s5;
	logic [2:0][31:0] wr_s5, wr_s6;
	logic signed [41:0] p_s6 [9];
	logic signed [57:0] pph_s7 [9];
	logic signed [48:0] ppl_s7 [9];
	logic signed [46:0] diff_s8 [9];
	logic signed [62:0] dho_s9 [9];
	logic signed [48:0] dlo_s9 [9];
	logic [8:0][31:0] out_s10;
	logic [31:0] rho_s10, ux_s10, uy_s10;

	function automatic logic [34:0] ext35(input logic [31:0] v);
		return {{3{v[31]}}, v};
	endfunction

	function automatic logic [31:0] vel(input div_res_t r, input logic neg, input logic zero);
		logic [31:0] v;
		if (zero) begin
			v = '0;
		end else if (neg) begin
			if (r.ovf || r.quo > 33'h0_8000_0000) begin
				v = 32'h8000_0000;
			end else begin
				v = 32'(-r.quo);
			end
		end else if (r.ovf || r.quo >= 33'h0_8000_0000) begin
			v = 32'h7fff_ffff;
		end else begin
			v = r.quo[31:0];
		end
		return v;
	endfunction

	assign en            = !v_s10 || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			omega_q <= OMEGA_RESET;
		end else if (cfg_valid) begin
			omega_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			vd_s  <= '0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s1  <= s_axis_tvalid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			vd_s  <= {vd_s[DIV_STAGES-2:0], v_s3};
			v_s4  <= vd_s[DIV_STAGES-1];
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// Moments.
	always_ff @(posedge clk) begin
		if (en) begin
			f_s1 <= s_axis_tdata;
			f_s2 <= f_s1;
			mx_s2 <= $signed(ext35(f_s1[1]) - ext35(f_s1[3]) + ext35(f_s1[5])
				- ext35(f_s1[6]) - ext35(f_s1[7]) + ext35(f_s1[8]));
			my_s2 <= $signed(ext35(f_s1[2]) - ext35(f_s1[4]) + ext35(f_s1[5])
				+ ext35(f_s1[6]) - ext35(f_s1[7]) - ext35(f_s1[8]));
			sum_s2 <= $signed({f_s1[0][31], ext35(f_s1[0])} + {f_s1[1][31], ext35(f_s1[1])}
				+ {f_s1[2][31], ext35(f_s1[2])} + {f_s1[3][31], ext35(f_s1[3])}
				+ {f_s1[4][31], ext35(f_s1[4])} + {f_s1[5][31], ext35(f_s1[5])}
				+ {f_s1[6][31], ext35(f_s1[6])} + {f_s1[7][31], ext35(f_s1[7])}
				+ {f_s1[8][31], ext35(f_s1[8])});
		end
	end

	logic [31:0] rho_c;
	assign rho_c = sat32(50'(sum_s2));

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3.f    <= f_s2;
			side_s3.rho  <= rho_c;
			side_s3.negx <= mx_s2[34] ^ rho_c[31];
			side_s3.negy <= my_s2[34] ^ rho_c[31];
			side_s3.zero <= rho_c == 32'h0;
			mxm_s3 <= mx_s2[34] ? NUM_W'(-mx_s2) : NUM_W'(mx_s2);
			mym_s3 <= my_s2[34] ? NUM_W'(-my_s2) : NUM_W'(my_s2);
			den_s3 <= rho_c[31] ? 32'(-rho_c) : rho_c;
		end
	end

	d2q_div u_div_x (.clk(clk), .en(en), .num_mag(mxm_s3), .den_mag(den_s3), .res(resx));
	d2q_div u_div_y (.clk(clk), .en(en), .num_mag(mym_s3), .den_mag(den_s3), .res(resy));

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_s3;
			for (int k = 1; k < DIV_STAGES; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// Velocity sign and saturation.
	always_ff @(posedge clk) begin
		if (en) begin
			node_s4.f   <= side_s[DIV_STAGES-1].f;
			node_s4.rho <= side_s[DIV_STAGES-1].rho;
			node_s4.ux  <= vel(resx, side_s[DIV_STAGES-1].negx, side_s[DIV_STAGES-1].zero);
			node_s4.uy  <= vel(resy, side_s[DIV_STAGES-1].negy, side_s[DIV_STAGES-1].zero);
		end
	end

	// Velocity products and weighted densities.
	logic signed [63:0] pxx, pyy, pxy;
	logic signed [59:0] pwr, pwa, pwd;
	always_comb begin
		pxx = $signed(node_s4.ux) * $signed(node_s4.ux);
		pyy = $signed(node_s4.uy) * $signed(node_s4.uy);
		pxy = $signed(node_s4.ux) * $signed(node_s4.uy);
		pwr = W_REST * $signed(node_s4.rho);
		pwa = W_AXIS * $signed(node_s4.rho);
		pwd = W_DIAG * $signed(node_s4.rho);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			node_s5 <= node_s4;
			uxx_s5  <= pxx[63:28];
			uyy_s5  <= pyy[63:28];
			uxy_s5  <= pxy[63:28];
			ux3_s5  <= 34'($signed(node_s4.ux)) * 34'sd3;
			uy3_s5  <= 34'($signed(node_s4.uy)) * 34'sd3;
			wr_s5   <= {pwd[59:28], pwa[59:28], pwr[59:28]};
		end
	end

	// Equilibrium polynomials.
	logic signed [41:0] usq, h15, t3, ax, ay, u9, x3, y3;
	always_comb begin
		usq = 42'(uxx_s5) + 42'(uyy_s5);
		t3  = usq * 42'sd3;
		h15 = t3 >>> 1;
		ax  = (42'(uxx_s5) * 42'sd9) >>> 1;
		ay  = (42'(uyy_s5) * 42'sd9) >>> 1;
		u9  = 42'(uxy_s5) * 42'sd9;
		x3  = 42'(ux3_s5);
		y3  = 42'(uy3_s5);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			node_s6 <= node_s5;
			wr_s6   <= wr_s5;
			p_s6[0] <= ONE_Q - h15;
			p_s6[1] <= ONE_Q + x3 + ax - h15;
			p_s6[2] <= ONE_Q + y3 + ay - h15;
			p_s6[3] <= ONE_Q - x3 + ax - h15;
			p_s6[4] <= ONE_Q - y3 + ay - h15;
			p_s6[5] <= ONE_Q + x3 + y3 + u9 + t3;
			p_s6[6] <= ONE_Q - x3 + y3 - u9 + t3;
			p_s6[7] <= ONE_Q - x3 - y3 + u9 + t3;
			p_s6[8] <= ONE_Q + x3 - y3 - u9 + t3;
		end
	end

	// feq = floor(p * wr / 2^28), split into two partial products.
	always_ff @(posedge clk) begin
		if (en) begin
			node_s7 <= node_s6;
			for (int i = 0; i < 9; i++) begin
				pph_s7[i] <= $signed(p_s6[i][41:16])
					* $signed(wr_s6[(i == 0) ? 0 : ((i < 5) ? 1 : 2)]);
				ppl_s7[i] <= $signed({1'b0, p_s6[i][15:0]})
					* $signed(wr_s6[(i == 0) ? 0 : ((i < 5) ? 1 : 2)]);
			end
		end
	end

	logic signed [73:0] feq_full [9];
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			feq_full[i] = $signed({pph_s7[i], 16'h0}) + 74'(ppl_s7[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			node_s8 <= node_s7;
			for (int i = 0; i < 9; i++) begin
				diff_s8[i] <= 47'($signed(node_s7.f[i])) - 47'($signed(feq_full[i][73:28]));
			end
		end
	end

	// Relaxation product, again in two parts.
	always_ff @(posedge clk) begin
		if (en) begin
			node_s9 <= node_s8;
			for (int i = 0; i < 9; i++) begin
				dho_s9[i] <= $signed(diff_s8[i][46:16]) * $signed({1'b0, omega_q});
				dlo_s9[i] <= $signed({1'b0, diff_s8[i][15:0]}) * $signed({1'b0, omega_q});
			end
		end
	end

	logic signed [78:0] rel_full [9];
	logic signed [49:0] post [9];
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			rel_full[i] = $signed({dho_s9[i], 16'h0}) + 79'(dlo_s9[i]);
			post[i]     = 50'($signed(node_s9.f[i])) - 50'($signed(rel_full[i][78:30]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rho_s10 <= node_s9.rho;
			ux_s10  <= node_s9.ux;
			uy_s10  <= node_s9.uy;
			for (int i = 0; i < 9; i++) begin
				out_s10[i] <= sat32(post[i]);
			end
		end
	end

	assign m_axis_tvalid = v_s10;
	assign m_axis_tdata  = {uy_s10, ux_s10, rho_s10, out_s10};

	logic [DIV_STAGES+9:0] vall;
	assign vall = {v_s1, v_s2, v_s3, vd_s, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10};

	a_zero_density_zero_velocity : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[319:288] == 32'h0 |-> m_axis_tdata[383:320] == 64'h0)
		else $error("nonzero velocity at zero density");

	a_stall_freezes_pipeline : assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vall))
		else $error("pipeline valid bits moved during a stall");

	a_no_accept_on_stall : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> v_s10)
		else $error("stalled result lost");

endmodule

>>> hw/rtl/d2q_div.sv
`timescale 1ns / 1ps
// Pipelined unsigned divider for the velocity: (num_mag * 2^28) / den_mag.
// Depends on d2q_pkg; DIV_STAGES register stages, advancing on en.
module d2q_div import d2q_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num_mag,
	input  logic [31:0]      den_mag,
	output div_res_t         res
);

	div_st_t init;
	div_st_t dst_s [DIV_STAGES];

	// Quotients of 2^33 and above only saturate, so they are flagged up front.
	always_comb begin
		init.ovf  = {2'b00, num_mag} >= {den_mag, 5'b00000};
		init.rem  = 32'(num_mag >> 5);
		init.bits = {num_mag[4:0], 28'h0};
		init.quo  = '0;
		init.den  = den_mag;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dst_s[0] <= div_step(init);
			for (int k = 1; k < DIV_STAGES; k++) begin
				dst_s[k] <= div_step(dst_s[k-1]);
			end
		end
	end

	assign res.ovf = dst_s[DIV_STAGES-1].ovf;
	assign res.quo = dst_s[DIV_STAGES-1].quo;

endmodule
